@@ src/isort_pkg.sv @@
package isort_pkg;

  localparam int unsigned MaxElements = 64;
  localparam int unsigned DataW       = 32;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last;
  } req_t;

  typedef struct packed {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_res;
    logic                    overflow;
  } result_t;

endpackage

@@ src/insertion_sorter_unit.sv @@
// Sorts a set of signed 32-bit values held in one single-port-read,
// single-port-write memory of MaxElements entries. A request is taken when
// start is high and busy is low. Inserting into a set that already holds c
// values moves the s stored values greater than the new one up by one entry,
// one entry per cycle through the memory read port, while busy stays high;
// into an empty set the new value is written at once, and into a full set it
// is dropped, with no shift. A request flagged last then streams the set in
// ascending order, one result per cycle on consecutive cycles, once the
// insertion ends, from the registered memory read port, with result_valid_o
// as strobe; results cannot be stalled and must be captured when shown.
// Values beyond MaxElements are dropped and set overflow on every result of
// that set.
module insertion_sorter_unit #(
  parameter int unsigned MaxElements = isort_pkg::MaxElements
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  isort_pkg::req_t     req_i,
  output logic                result_valid_o,
  output isort_pkg::result_t  result_o
);

  localparam int unsigned AddrW = $clog2(MaxElements);

  logic                          we;
  logic [AddrW-1:0]              waddr;
  logic [isort_pkg::DataW-1:0]   wdata;
  logic                          re;
  logic [AddrW-1:0]              raddr;
  logic [isort_pkg::DataW-1:0]   rdata;

  isort_ctrl #(
    .MaxElements(MaxElements)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .we_o          (we),
    .waddr_o       (waddr),
    .wdata_o       (wdata),
    .re_o          (re),
    .raddr_o       (raddr),
    .rdata_i       (rdata)
  );

  isort_store #(
    .Depth(MaxElements)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

@@ src/isort_store.sv @@
module isort_store #(
  parameter int unsigned Depth = isort_pkg::MaxElements,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [isort_pkg::DataW-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [isort_pkg::DataW-1:0]   rdata_o
);

  logic [isort_pkg::DataW-1:0] mem [Depth];
  logic [isort_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/isort_ctrl.sv @@
module isort_ctrl #(
  parameter int unsigned MaxElements = isort_pkg::MaxElements,
  parameter int unsigned AddrW       = $clog2(MaxElements),
  parameter int unsigned CntW        = $clog2(MaxElements + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  isort_pkg::req_t               req_i,
  output logic                          result_valid_o,
  output isort_pkg::result_t            result_o,
  output logic                          we_o,
  output logic [AddrW-1:0]              waddr_o,
  output logic [isort_pkg::DataW-1:0]   wdata_o,
  output logic                          re_o,
  output logic [AddrW-1:0]              raddr_o,
  input  logic [isort_pkg::DataW-1:0]   rdata_i
);

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StPlace,
    StEmit
  } state_e;

  state_e                         state_q, state_d;
  logic [CntW-1:0]                count_q, count_d;
  logic                           dropped_q, dropped_d;
  logic signed [isort_pkg::DataW-1:0] val_q, val_d;
  logic                           last_q, last_d;
  logic [AddrW-1:0]               pos_q, pos_d;
  logic [AddrW-1:0]               idx_q, idx_d;
  logic                           out_v_q, out_v_d;
  logic                           out_last_q, out_last_d;
  logic                           out_ovf_q, out_ovf_d;
  logic                           emit_last;

  assign emit_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dropped_d  = dropped_q;
    val_d      = val_q;
    last_d     = last_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    out_v_d    = 1'b0;
    out_last_d = 1'b0;
    out_ovf_d  = 1'b0;
    we_o       = 1'b0;
    waddr_o    = pos_q;
    wdata_o    = val_q;
    re_o       = 1'b0;
    raddr_o    = idx_q;

    unique case (state_q)
      StIdle: begin
        if (start) begin
          idx_d = '0;
          if (count_q == CntW'(MaxElements)) begin
            dropped_d = 1'b1;
            if (req_i.last) begin
              state_d = StEmit;
            end
          end else if (count_q == '0) begin
            we_o    = 1'b1;
            waddr_o = '0;
            wdata_o = req_i.value;
            count_d = CntW'(1);
            if (req_i.last) begin
              state_d = StEmit;
            end
          end else begin
            re_o    = 1'b1;
            raddr_o = count_q[AddrW-1:0] - AddrW'(1);
            val_d   = req_i.value;
            last_d  = req_i.last;
            pos_d   = count_q[AddrW-1:0];
            state_d = StShift;
          end
        end
      end
      StShift: begin
        we_o    = 1'b1;
        waddr_o = pos_q;
        if ($signed(rdata_i) > val_q) begin
          wdata_o = rdata_i;
          if (pos_q == AddrW'(1)) begin
            pos_d   = '0;
            state_d = StPlace;
          end else begin
            re_o    = 1'b1;
            raddr_o = pos_q - AddrW'(2);
            pos_d   = pos_q - AddrW'(1);
          end
        end else begin
          wdata_o = val_q;
          count_d = count_q + CntW'(1);
          state_d = last_q ? StEmit : StIdle;
        end
      end
      StPlace: begin
        we_o    = 1'b1;
        waddr_o = '0;
        wdata_o = val_q;
        count_d = count_q + CntW'(1);
        state_d = last_q ? StEmit : StIdle;
      end
      StEmit: begin
        re_o       = 1'b1;
        raddr_o    = idx_q;
        out_v_d    = 1'b1;
        out_last_d = emit_last;
        out_ovf_d  = dropped_q;
        idx_d      = idx_q + AddrW'(1);
        if (emit_last) begin
          count_d   = '0;
          dropped_d = 1'b0;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      dropped_q  <= 1'b0;
      last_q     <= 1'b0;
      pos_q      <= '0;
      idx_q      <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_ovf_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      dropped_q  <= dropped_d;
      last_q     <= last_d;
      pos_q      <= pos_d;
      idx_q      <= idx_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
      out_ovf_q  <= out_ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign busy                  = (state_q != StIdle);
  assign result_valid_o        = out_v_q;
  assign result_o.sorted_value = $signed(rdata_i);
  assign result_o.last_res     = out_last_q;
  assign result_o.overflow     = out_ovf_q;

endmodule

@@ src/isort_checker.sv @@
module isort_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input isort_pkg::req_t     req_i,
  input logic                result_valid_o,
  input isort_pkg::result_t  result_o
);

  a_no_result_after_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !req_i.last |=> !result_valid_o)
    else $error("result after a request not flagged last");

  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.last |=> busy)
    else $error("busy not raised after a last request");

  a_stream_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_res |=> result_valid_o)
    else $error("gap inside a result stream");

  a_busy_during_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_res |-> busy)
    else $error("idle while results remain");

  a_overflow_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_res |=> $stable(result_o.overflow))
    else $error("overflow changed within a set");

endmodule

bind insertion_sorter_unit isort_checker u_isort_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .req_i         (req_i),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
